### rtl/core/dcm_pkg.sv
// Shared types, constants and helpers for the DC motor RK4 plant emulator.
package dcm_pkg;

  localparam int SIG_W     = 32;
  localparam int COEF_W    = 32;
  localparam int PROD_W    = 64;
  localparam int SAT_W     = 48;
  localparam int ACC_W     = 42;
  localparam int INC_W     = 43;
  localparam int MAG_W     = 44;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 6;
  localparam int STEP_W    = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_EMF_CONST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_CONST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION_COEF  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_INDUCTANCE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_INERTIA    = 3'd6;

  localparam logic [COEF_W-1:0] RST_TIME_STEP      = 32'd16777;
  localparam logic [COEF_W-1:0] RST_RESISTANCE     = 32'd16777216;
  localparam logic [COEF_W-1:0] RST_BACK_EMF_CONST = 32'd167772;
  localparam logic [COEF_W-1:0] RST_TORQUE_CONST   = 32'd167772;
  localparam logic [COEF_W-1:0] RST_FRICTION_COEF  = 32'd16777;
  localparam logic [COEF_W-1:0] RST_INV_INDUCTANCE = 32'd33554432;
  localparam logic [COEF_W-1:0] RST_INV_INERTIA    = 32'd1677721600;

  localparam logic signed [SAT_W-1:0] SAT_HI = 48'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_LO = -48'sd2147483648;

  typedef struct packed {
    logic [COEF_W-1:0] time_step;
    logic [COEF_W-1:0] resistance;
    logic [COEF_W-1:0] back_emf_const;
    logic [COEF_W-1:0] torque_const;
    logic [COEF_W-1:0] friction_coef;
    logic [COEF_W-1:0] inv_inductance;
    logic [COEF_W-1:0] inv_inertia;
  } dcm_cfg_t;

  typedef struct packed {
    logic [COEF_W-1:0]        coef;
    logic signed [SIG_W-1:0]  sig;
  } mul_req_t;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIV, S_DONE} state_t;

  // multiplier slots within one derivative evaluation
  typedef enum logic [2:0] {
    OP_RI, OP_KBW, OP_KTI, OP_BW, OP_LA, OP_JB, OP_DTI, OP_DTW
  } op_t;

  function automatic logic signed [SIG_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SIG_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[SIG_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/dcm_if.sv
// Request channel interfaces: input sample, result and configuration write.
interface dcm_in_if import dcm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SIG_W-1:0] control_voltage;
  logic signed [SIG_W-1:0] load_torque;
  modport source (output valid, control_voltage, load_torque, input ready);
  modport sink   (input valid, control_voltage, load_torque, output ready);
endinterface

interface dcm_out_if import dcm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SIG_W-1:0] next_current;
  logic signed [SIG_W-1:0] next_speed;
  modport source (output valid, next_current, next_speed, input ready);
  modport sink   (input valid, next_current, next_speed, output ready);
endinterface

interface dcm_cfg_if import dcm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [COEF_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/dcm_regs.sv
// Motor constant register file behind the configuration write channel.
module dcm_regs import dcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dcm_cfg_if.sink   cfg,
  output dcm_cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.time_step      <= RST_TIME_STEP;
      regs.resistance     <= RST_RESISTANCE;
      regs.back_emf_const <= RST_BACK_EMF_CONST;
      regs.torque_const   <= RST_TORQUE_CONST;
      regs.friction_coef  <= RST_FRICTION_COEF;
      regs.inv_inductance <= RST_INV_INDUCTANCE;
      regs.inv_inertia    <= RST_INV_INERTIA;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TIME_STEP:      regs.time_step      <= cfg.data;
        REG_RESISTANCE:     regs.resistance     <= cfg.data;
        REG_BACK_EMF_CONST: regs.back_emf_const <= cfg.data;
        REG_TORQUE_CONST:   regs.torque_const   <= cfg.data;
        REG_FRICTION_COEF:  regs.friction_coef  <= cfg.data;
        REG_INV_INDUCTANCE: regs.inv_inductance <= cfg.data;
        REG_INV_INERTIA:    regs.inv_inertia    <= cfg.data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

endmodule

### rtl/core/dcm_mul.sv
// Shared registered multiplier: unsigned Q8.24 coefficient times signed signal.
module dcm_mul import dcm_pkg::*; (
  input  logic                     clk,
  input  mul_req_t                 req,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W:0] full;

  assign full = $signed({1'b0, req.coef}) * $signed(req.sig);

  always_ff @(posedge clk) begin
    prod <= full[PROD_W-1:0];
  end

endmodule

### rtl/core/dcm_div6.sv
// Floor division by six of a signed word, four quotient bits per cycle.
module dcm_div6 import dcm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [INC_W-1:0] value,
  output logic                    done,
  output logic signed [INC_W-1:0] quot
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W / 4 - 1);

  logic              busy;
  logic              neg;
  logic [STEP_W-1:0] step;
  logic [MAG_W-1:0]  work, work_next;
  logic [2:0]        rem, rem_next;
  logic signed [MAG_W-1:0] vx;
  logic [MAG_W-1:0]  mag;

  assign vx  = MAG_W'(value);
  // floor for negatives: -ceil(|v|/6) = -((|v|+5) div 6)
  assign mag = vx[MAG_W-1] ? MAG_W'(-vx + 44'sd5) : MAG_W'(vx);

  always_comb begin
    logic [3:0] r;
    work_next = work;
    rem_next  = rem;
    for (int k = 0; k < 4; k++) begin
      r = {rem_next, work_next[MAG_W-1]};
      work_next = {work_next[MAG_W-2:0], 1'b0};
      if (r >= 4'd6) begin
        rem_next     = 3'(r - 4'd6);
        work_next[0] = 1'b1;
      end else begin
        rem_next = r[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= mag;
      rem  <= '0;
      neg  <= vx[MAG_W-1];
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quot = neg ? -$signed(INC_W'(work)) : $signed(INC_W'(work));

endmodule

### rtl/core/dc_motor_rk4_step.sv
// Top level of the DC motor RK4 plant emulator: sequencer and state.
//
// One request in, one result out. Each sample request (control voltage,
// load torque) advances the armature current and shaft speed by one
// classical RK4 step and returns the new pair, saturated to Q16.16. The
// block is not ready for a new request while it works on one. The run
// phase drives the single shared 32x33 multiplier through four derivative
// evaluations of eight products each (six for the derivatives, two for
// dt*k). The two radix-16 divide-by-six lanes then form the weighted
// increment, and their finish writes the state; then the result register
// is loaded and the next request taken. A new request is taken while the
// previous result still waits downstream; the block holds only if a
// second result is ready before the first is taken. The user must write motor
// constants through the cfg channel while idle; not enforced by the block.
module dc_motor_rk4_step import dcm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dcm_in_if.sink     sample,
  dcm_out_if.source  result,
  dcm_cfg_if.sink    cfg
);

  localparam logic [CNT_W-1:0] CNT_ISSUED = 6'd32;  // last product consumed
  localparam logic [CNT_W-1:0] CNT_LAST   = 6'd33;  // increments complete
  localparam logic [1:0]       STAGE_LAST = 2'd3;

  dcm_cfg_t regs;
  state_t   state, state_next;

  // stored motor state and request operands
  logic signed [SIG_W-1:0] motor_current, motor_speed;
  logic signed [SIG_W-1:0] u_reg, tl_reg;
  logic signed [SIG_W-1:0] cur_i, cur_w;      // point of the present evaluation
  logic signed [SIG_W-1:0] a_reg, b_reg;      // saturated brackets
  logic signed [SIG_W-1:0] ki, kw;            // saturated derivatives
  logic signed [ACC_W-1:0] acc_a, acc_b;
  logic signed [INC_W-1:0] inc_i, inc_w;
  logic [CNT_W-1:0]        cnt;

  // multiplier
  mul_req_t                 req;
  logic signed [PROD_W-1:0] prod;
  logic signed [39:0]       ps24;
  logic signed [38:0]       ps25;

  // sequencer decode
  op_t        op, cop;
  logic [4:0] cm1;
  logic [1:0] cstage;
  logic       consume_en;
  logic       accept;
  logic       div_start, div_done_i, div_done_w, load_out;
  logic signed [INC_W-1:0] q_i, q_w;
  logic signed [INC_W-1:0] term, wterm;
  logic signed [SAT_W-1:0] step_add;

  dcm_regs u_regs (.clk, .rst, .cfg, .regs);
  dcm_mul  u_mul  (.clk, .req, .prod);

  dcm_div6 u_div_i (.clk, .rst, .start(div_start), .value(inc_i),
                    .done(div_done_i), .quot(q_i));
  dcm_div6 u_div_w (.clk, .rst, .start(div_start), .value(inc_w),
                    .done(div_done_w), .quot(q_w));

  assign accept = sample.valid && sample.ready;

  // issue slot follows the counter; the consume slot trails it by one
  assign op         = op_t'(cnt[2:0]);
  assign cm1        = 5'(cnt - 6'd1);
  assign cop        = op_t'(cm1[2:0]);
  assign cstage     = cm1[4:3];
  assign consume_en = (state == S_RUN) && (cnt != '0) && (cnt != CNT_LAST);

  assign ps24 = $signed(prod[PROD_W-1:24]);
  assign ps25 = $signed(prod[PROD_W-1:25]);

  // RK4 weights 1,2,2,1; the two inner evaluations use the half step
  assign term     = INC_W'(ps24);
  assign wterm    = (cstage == 2'd1 || cstage == 2'd2) ? (term <<< 1) : term;
  assign step_add = (cstage == 2'd0 || cstage == 2'd1) ? SAT_W'(ps25) : SAT_W'(ps24);

  always_comb begin
    req.sig  = cur_i;
    req.coef = regs.time_step;
    case (op)
      OP_RI:   begin req.coef = regs.resistance;     req.sig = cur_i; end
      OP_KBW:  begin req.coef = regs.back_emf_const; req.sig = cur_w; end
      OP_KTI:  begin req.coef = regs.torque_const;   req.sig = cur_i; end
      OP_BW:   begin req.coef = regs.friction_coef;  req.sig = cur_w; end
      OP_LA:   begin req.coef = regs.inv_inductance; req.sig = a_reg; end
      OP_JB:   begin req.coef = regs.inv_inertia;    req.sig = b_reg; end
      OP_DTI:  begin req.coef = regs.time_step;      req.sig = ki;    end
      OP_DTW:  begin req.coef = regs.time_step;      req.sig = kw;    end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (sample.valid) state_next = S_RUN;
      S_RUN:  if (cnt == CNT_LAST) state_next = S_DIV;
      S_DIV:  if (div_done_i) state_next = S_DONE;
      S_DONE: if (!result.valid || result.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    sample.ready = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    case (state)
      S_IDLE: sample.ready = 1'b1;
      S_RUN:  div_start    = (cnt == CNT_LAST);
      S_DONE: load_out     = !result.valid || result.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      motor_current <= '0;
      motor_speed   <= '0;
      result.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (state == S_RUN) begin
        cnt <= cnt + 1'b1;
      end
      if (state == S_DIV && div_done_i) begin
        motor_current <= sat32(SAT_W'(motor_current) + SAT_W'(q_i));
        motor_speed   <= sat32(SAT_W'(motor_speed) + SAT_W'(q_w));
      end
      if (load_out) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      u_reg  <= sample.control_voltage;
      tl_reg <= sample.load_torque;
      cur_i  <= motor_current;
      cur_w  <= motor_speed;
      inc_i  <= '0;
      inc_w  <= '0;
    end else if (consume_en) begin
      case (cop)
        OP_RI:  acc_a <= ACC_W'(u_reg) - ACC_W'(ps24);
        OP_KBW: a_reg <= sat32(SAT_W'(acc_a) - SAT_W'(ps24));
        OP_KTI: acc_b <= ACC_W'(ps24) - ACC_W'(tl_reg);
        OP_BW:  b_reg <= sat32(SAT_W'(acc_b) - SAT_W'(ps24));
        OP_LA:  ki    <= sat32(SAT_W'(ps24));
        OP_JB:  kw    <= sat32(SAT_W'(ps24));
        OP_DTI: begin
          inc_i <= inc_i + wterm;
          if (cstage != STAGE_LAST) cur_i <= sat32(SAT_W'(motor_current) + step_add);
        end
        OP_DTW: begin
          inc_w <= inc_w + wterm;
          if (cstage != STAGE_LAST) cur_w <= sat32(SAT_W'(motor_speed) + step_add);
        end
        default: ;
      endcase
    end
    if (load_out) begin
      result.next_current <= motor_current;
      result.next_speed   <= motor_speed;
    end
  end

  // both divide lanes start together and must finish together
  a_div_lanes: assert property (@(posedge clk) disable iff (rst)
    div_done_i == div_done_w)
    else $error("divide lanes out of step");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done_i |-> state == S_DIV)
    else $error("divide finished outside divide phase");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_RUN && cnt == '0)
    else $error("accepted request did not start the sequence");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN && cnt == CNT_LAST |=> state == S_DIV)
    else $error("sequence did not hand over to the divider");

  a_consume_range: assert property (@(posedge clk) disable iff (rst)
    consume_en |-> cnt <= CNT_ISSUED)
    else $error("product consumed past last slot");

endmodule
